### hw/rtl/round_robin_thread_scheduler_assert.svh
// Assertion macros shared by the scheduler modules.
// Expects signals named clk and rst in the module that uses them.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RRTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rrts_pkg.sv
// Shared types and constants of the round-robin thread scheduler.
// No dependencies.
package rrts_pkg;

  localparam int unsigned MAX_TASKS = 16;
  localparam int unsigned TASK_W    = 4;
  localparam int unsigned IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned COUNT_W   = $clog2(MAX_TASKS + 1);
  localparam int unsigned SUM_W     = COUNT_W + 1;

  typedef enum logic [2:0] {
    ACT_INIT    = 3'd0,
    ACT_START   = 3'd1,
    ACT_YIELD   = 3'd2,
    ACT_BLOCK   = 3'd3,
    ACT_UNBLOCK = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_RUNNING = 3'd1,
    ST_READY   = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_WAITING = 3'd4,
    ST_HANGING = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_EMPTY  = 2'd1,
    ERR_STATUS = 2'd2,
    ERR_QUEUED = 2'd3
  } err_t;

  localparam logic [1:0] KIND_MAX = 2'd2;

  typedef struct packed {
    logic [2:0]        action;
    logic [TASK_W-1:0] task_id;
    logic [1:0]        block_kind;
  } act_item_t;

  typedef struct packed {
    logic [TASK_W-1:0] running_task;
    logic              switched;
    logic [1:0]        error_code;
  } res_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic disp;
    logic publish;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_disp;
  } dp_sts_t;

endpackage

### hw/rtl/rrts_ctrl.sv
// Sequencer of the thread scheduler: load, evaluate, dispatch, publish.
// Depends on rrts_pkg and round_robin_thread_scheduler_assert.svh.
`include "round_robin_thread_scheduler_assert.svh"

module rrts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               act_valid,
  output logic               act_stall,
  output logic               res_valid,
  input  logic               res_stall,
  output rrts_pkg::ctl_cmd_t ctl,
  input  rrts_pkg::dp_sts_t  sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DISP = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign act_stall = (state != S_IDLE);
  assign out_free  = !res_valid || !res_stall;

  always_comb begin
    ctl.load    = (state == S_IDLE) && act_valid;
    ctl.eval    = (state == S_EVAL);
    ctl.disp    = (state == S_DISP);
    ctl.publish = (state == S_DONE) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (act_valid) state_next = S_EVAL;
      S_EVAL: state_next = sts.need_disp ? S_DISP : S_DONE;
      S_DISP: state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.publish) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  `RRTS_ASSERT_NEXT(a_accept_starts_eval, act_valid && !act_stall, state == S_EVAL, "accept did not start evaluation")
  `RRTS_ASSERT_NEXT(a_publish_shows_result, ctl.publish, res_valid, "published result not shown")
  `RRTS_ASSERT_NEXT(a_done_waits_on_stall, (state == S_DONE) && res_valid && res_stall, state == S_DONE, "result overwritten while stalled")

endmodule

### hw/rtl/rrts_dp.sv
// Datapath of the thread scheduler: status memory, ready ring, pointers, result.
// Depends on rrts_pkg and round_robin_thread_scheduler_assert.svh.
`include "round_robin_thread_scheduler_assert.svh"

module rrts_dp (
  input  logic                clk,
  input  logic                rst,
  input  rrts_pkg::ctl_cmd_t  ctl,
  output rrts_pkg::dp_sts_t   sts,
  input  rrts_pkg::act_item_t act_item,
  output rrts_pkg::res_item_t res_item
);

  localparam int unsigned N = rrts_pkg::MAX_TASKS;

  // status memory, valid bits give the all-none reset
  rrts_pkg::status_t                 status_mem [N];
  logic [N-1:0]                      status_vld;
  rrts_pkg::status_t                 status_rd;
  logic                              status_rd_vld;
  // ready ring, contents undefined until written
  logic [rrts_pkg::TASK_W-1:0]       ring_mem [N];
  logic [rrts_pkg::TASK_W-1:0]       ring_rd;

  logic [rrts_pkg::IDX_W-1:0]        head, head_next, head_inc, head_dec, tail_ptr;
  logic [rrts_pkg::COUNT_W-1:0]      count, count_next;
  logic [rrts_pkg::TASK_W-1:0]       current, cur_next, nxt_task;
  logic [N-1:0]                      queued, queued_next;
  logic [rrts_pkg::IDX_W-1:0]        disp_idx;
  rrts_pkg::act_item_t               item;
  rrts_pkg::res_item_t               result;

  logic [rrts_pkg::SUM_W-1:0]        tail_sum;
  logic [rrts_pkg::IDX_W-1:0]        cur_idx, id_idx, nxt_idx, rd_idx;
  rrts_pkg::status_t                 st;
  logic                              id_ok, id_q, cur_q, full, run, st_blk;

  rrts_pkg::err_t                    err;
  logic                              sw;
  logic                              st_we, rg_we, set_en, clr_en, need_disp;
  logic [rrts_pkg::IDX_W-1:0]        st_waddr, rg_waddr, set_idx, clr_idx;
  rrts_pkg::status_t                 st_wdata;
  logic [rrts_pkg::TASK_W-1:0]       rg_wdata;

  logic                              mem_we;
  logic [rrts_pkg::IDX_W-1:0]        mem_waddr;
  rrts_pkg::status_t                 mem_wdata;

  assign cur_idx = rrts_pkg::IDX_W'(current);
  assign id_idx  = rrts_pkg::IDX_W'(item.task_id);
  assign nxt_idx = rrts_pkg::IDX_W'(nxt_task);
  assign rd_idx  = ((act_item.action == rrts_pkg::ACT_YIELD) ||
                    (act_item.action == rrts_pkg::ACT_BLOCK)) ? cur_idx
                   : rrts_pkg::IDX_W'(act_item.task_id);

  // ring pointer arithmetic with wrap at N
  assign tail_sum = rrts_pkg::SUM_W'(head) + rrts_pkg::SUM_W'(count);
  assign tail_ptr = (tail_sum >= rrts_pkg::SUM_W'(N))
                    ? rrts_pkg::IDX_W'(tail_sum - rrts_pkg::SUM_W'(N))
                    : rrts_pkg::IDX_W'(tail_sum);
  assign head_inc = (head == rrts_pkg::IDX_W'(N - 1)) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? rrts_pkg::IDX_W'(N - 1) : head - 1'b1;

  assign st     = status_rd_vld ? status_rd : rrts_pkg::ST_NONE;
  assign id_ok  = (32'(item.task_id) < N);
  assign id_q   = queued[id_idx];
  assign cur_q  = queued[cur_idx];
  assign full   = (count == rrts_pkg::COUNT_W'(N));
  assign run    = (st == rrts_pkg::ST_RUNNING);
  assign st_blk = (st == rrts_pkg::ST_BLOCKED) || (st == rrts_pkg::ST_WAITING) ||
                  (st == rrts_pkg::ST_HANGING);
  // ring empty before a yield append: the appended task is the new head
  assign nxt_task = (count == '0) ? current : ring_rd;

  always_comb begin
    err        = rrts_pkg::ERR_OK;
    sw         = 1'b0;
    cur_next   = current;
    st_we      = 1'b0;
    st_waddr   = cur_idx;
    st_wdata   = rrts_pkg::ST_NONE;
    rg_we      = 1'b0;
    rg_waddr   = tail_ptr;
    rg_wdata   = item.task_id;
    head_next  = head;
    count_next = count;
    set_en     = 1'b0;
    set_idx    = id_idx;
    clr_en     = 1'b0;
    clr_idx    = nxt_idx;
    need_disp  = 1'b0;
    unique case (item.action)
      rrts_pkg::ACT_INIT: begin
        if (!id_ok) begin
          err = rrts_pkg::ERR_STATUS;
        end else if (id_q) begin
          err = rrts_pkg::ERR_QUEUED;
        end else begin
          st_we    = 1'b1;
          st_waddr = id_idx;
          st_wdata = rrts_pkg::ST_RUNNING;
          cur_next = item.task_id;
        end
      end
      rrts_pkg::ACT_START: begin
        if (!id_ok) begin
          err = rrts_pkg::ERR_STATUS;
        end else if (id_q || full) begin
          err = rrts_pkg::ERR_QUEUED;
        end else begin
          st_we      = 1'b1;
          st_waddr   = id_idx;
          st_wdata   = (item.task_id == current) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_READY;
          rg_we      = 1'b1;
          count_next = count + 1'b1;
          set_en     = 1'b1;
        end
      end
      rrts_pkg::ACT_YIELD: begin
        if (run && (cur_q || full)) begin
          err = rrts_pkg::ERR_QUEUED;
        end else if (!run && (count == '0)) begin
          err = rrts_pkg::ERR_EMPTY;
        end else begin
          if (run) begin
            // requeue current as ready, the new head is marked running next cycle
            rg_we     = 1'b1;
            rg_wdata  = current;
            set_en    = 1'b1;
            set_idx   = cur_idx;
            st_we     = 1'b1;
            st_waddr  = cur_idx;
            st_wdata  = rrts_pkg::ST_READY;
            need_disp = 1'b1;
          end else begin
            st_we    = 1'b1;
            st_waddr = nxt_idx;
            st_wdata = rrts_pkg::ST_RUNNING;
          end
          head_next  = head_inc;
          count_next = run ? count : count - 1'b1;
          clr_en     = 1'b1;
          cur_next   = nxt_task;
          sw         = (nxt_task != current);
        end
      end
      rrts_pkg::ACT_BLOCK: begin
        if (item.block_kind > rrts_pkg::KIND_MAX) begin
          err = rrts_pkg::ERR_STATUS;
        end else if (count == '0) begin
          err = rrts_pkg::ERR_EMPTY;
        end else begin
          st_we      = 1'b1;
          st_waddr   = cur_idx;
          st_wdata   = rrts_pkg::status_t'(rrts_pkg::ST_BLOCKED + 3'(item.block_kind));
          need_disp  = 1'b1;
          head_next  = head_inc;
          count_next = count - 1'b1;
          clr_en     = 1'b1;
          cur_next   = nxt_task;
          sw         = (nxt_task != current);
        end
      end
      rrts_pkg::ACT_UNBLOCK: begin
        if (!id_ok || !st_blk) begin
          err = rrts_pkg::ERR_STATUS;
        end else if (id_q || full) begin
          err = rrts_pkg::ERR_QUEUED;
        end else begin
          head_next  = head_dec;
          rg_we      = 1'b1;
          rg_waddr   = head_dec;
          count_next = count + 1'b1;
          st_we      = 1'b1;
          st_waddr   = id_idx;
          st_wdata   = rrts_pkg::ST_READY;
          set_en     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // clear after set: a requeued task popped at once leaves the ring
  always_comb begin
    queued_next = queued;
    if (set_en) begin
      queued_next[set_idx] = 1'b1;
    end
    if (clr_en) begin
      queued_next[clr_idx] = 1'b0;
    end
  end

  assign sts.need_disp = need_disp;

  // single write port on the status memory, dispatch owns it in its own cycle
  assign mem_we    = (ctl.eval && st_we) || ctl.disp;
  assign mem_waddr = ctl.disp ? disp_idx : st_waddr;
  assign mem_wdata = ctl.disp ? rrts_pkg::ST_RUNNING : st_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      status_mem[mem_waddr] <= mem_wdata;
    end
    if (ctl.load) begin
      status_rd <= status_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval && rg_we) begin
      ring_mem[rg_waddr] <= rg_wdata;
    end
    if (ctl.load) begin
      ring_rd <= ring_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_vld    <= '0;
      status_rd_vld <= 1'b0;
      queued        <= '0;
      head          <= '0;
      count         <= '0;
      current       <= '0;
    end else begin
      if (mem_we) begin
        status_vld[mem_waddr] <= 1'b1;
      end
      if (ctl.load) begin
        status_rd_vld <= status_vld[rd_idx];
      end
      if (ctl.eval) begin
        head    <= head_next;
        count   <= count_next;
        current <= cur_next;
        queued  <= queued_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item <= act_item;
    end
    if (ctl.eval) begin
      disp_idx            <= nxt_idx;
      result.running_task <= cur_next;
      result.switched     <= sw;
      result.error_code   <= err;
    end
    if (ctl.publish) begin
      res_item <= result;
    end
  end

  `RRTS_ASSERT_NOW(a_count_range, 1'b1, count <= rrts_pkg::COUNT_W'(N), "ring count above depth")
  `RRTS_ASSERT_NOW(a_queued_matches_count, 1'b1, $countones(queued) == 32'(count), "queued set out of step with ring count")
  `RRTS_ASSERT_NOW(a_dispatch_popped, ctl.disp, !queued[disp_idx], "dispatched task still queued")

endmodule

### hw/rtl/round_robin_thread_scheduler.sv
// Round-robin thread scheduler, top level.
// Depends on rrts_pkg, rrts_ctrl and rrts_dp.
//
// Usage:
//   Action channel (act_valid / act_stall / act_item): one transfer is one
//   scheduler action (init main task, start, yield, block, unblock).
//   Result channel (res_valid / res_stall / res_item): exactly one transfer
//   per action, carrying the running task, a switch flag and an error code.
//   A failed check returns its error code and leaves all state untouched.
// Timing:
//   The block takes one action at a time. After an action transfer the
//   sequencer steps through evaluate, then dispatch for a yield that
//   requeues the current task and for block, since both write the status
//   memory twice through its single write port, then done, where the result
//   is registered. The next action is taken in the cycle after the result is registered.
// Reset (rst, synchronous): all task status reads as none, ring empty, head
//   and current task zero. No clearing pass; valid bits cover the status.
// Stall: a result held by res_stall keeps the sequencer waiting at its end,
//   and act_stall stays high until the result register frees up.

module round_robin_thread_scheduler (
  input  logic                clk,
  input  logic                rst,
  input  logic                act_valid,
  output logic                act_stall,
  input  rrts_pkg::act_item_t act_item,
  output logic                res_valid,
  input  logic                res_stall,
  output rrts_pkg::res_item_t res_item
);

  rrts_pkg::ctl_cmd_t ctl;
  rrts_pkg::dp_sts_t  sts;

  // sequencer: accepts actions and orders the datapath steps
  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .act_valid (act_valid),
    .act_stall (act_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  // datapath: status memory, ready ring, current task and result register
  rrts_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .act_item (act_item),
    .res_item (res_item)
  );

endmodule

### dv/tb_round_robin_thread_scheduler.sv
// Self-checking testbench for the round-robin thread scheduler.
// Needs rrts_pkg and the round_robin_thread_scheduler RTL; uses nothing else.
// Directed table first, then bursty random actions checked against a predictor.
module tb_round_robin_thread_scheduler;
  import rrts_pkg::*;

  localparam int unsigned N_RANDOM    = 1000;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_WAIT  = 16;    // a few times the action latency
  localparam int unsigned HOLDOFF_AT  = 2000;  // receiver cycle at which the long stall starts
  localparam int unsigned HOLDOFF_LEN = 300;

  // block_kind codes
  localparam logic [1:0] KIND_BLOCKED = 2'd0;
  localparam logic [1:0] KIND_WAITING = 2'd1;
  localparam logic [1:0] KIND_HANGING = 2'd2;
  localparam logic [1:0] KIND_BAD     = 2'd3;

  // action codes that the block must ignore
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  logic      clk;
  logic      rst       = 1'b1;
  logic      act_valid = 1'b0;
  logic      act_stall;
  act_item_t act_item  = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res_item;

  round_robin_thread_scheduler u_dut (
    .clk       (clk),
    .rst       (rst),
    .act_valid (act_valid),
    .act_stall (act_stall),
    .act_item  (act_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: per-task status, ready ring, running task.
  // ---------------------------------------------------------------------------
  status_t            task_state [MAX_TASKS];
  logic [TASK_W-1:0]  ready_ring [MAX_TASKS];
  logic [IDX_W-1:0]   ring_head;
  logic [COUNT_W-1:0] ring_count;
  logic [TASK_W-1:0]  running_id;

  res_item_t pending_results [$];  // expected result transfers, oldest first
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  function automatic void clear_sched_state();
    for (int t = 0; t < MAX_TASKS; t++) begin
      task_state[t] = ST_NONE;
      ready_ring[t] = '0;
    end
    ring_head  = '0;
    ring_count = '0;
    running_id = '0;
  endfunction

  // only slots inside the live window are looked at
  function automatic logic is_queued(input logic [TASK_W-1:0] id);
    for (int i = 0; i < ring_count; i++)
      if (ready_ring[IDX_W'(ring_head + i)] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void append_tail(input logic [TASK_W-1:0] id);
    ready_ring[IDX_W'(ring_head + ring_count)] = id;
    ring_count++;
  endfunction

  // pop the head into the running slot; returns the switch flag
  function automatic logic dispatch_head();
    logic [TASK_W-1:0] prev;
    logic [TASK_W-1:0] nxt;
    prev = running_id;
    nxt  = ready_ring[ring_head];
    ring_head++;
    ring_count--;
    task_state[nxt] = ST_RUNNING;
    running_id = nxt;
    return nxt != prev;
  endfunction

  // Applies one action to the predictor state and returns the result it yields.
  // A failing check leaves the state untouched.
  function automatic res_item_t sched_next(input act_item_t it);
    res_item_t         r;
    logic [TASK_W-1:0] id;
    logic [TASK_W-1:0] cur;
    err_t              err;
    logic              sw;
    id  = it.task_id;
    cur = running_id;
    err = ERR_OK;
    sw  = 1'b0;
    case (it.action)
      ACT_INIT: begin
        if (is_queued(id)) err = ERR_QUEUED;
        else begin
          task_state[id] = ST_RUNNING;
          running_id = id;
        end
      end
      ACT_START: begin
        if (is_queued(id) || ring_count >= MAX_TASKS) err = ERR_QUEUED;
        else begin
          task_state[id] = (id == running_id) ? ST_RUNNING : ST_READY;
          append_tail(id);
        end
      end
      ACT_YIELD: begin
        // a running task goes back to the tail before the head is taken
        if (task_state[cur] == ST_RUNNING && (is_queued(cur) || ring_count >= MAX_TASKS)) begin
          err = ERR_QUEUED;
        end else begin
          if (task_state[cur] == ST_RUNNING) begin
            append_tail(cur);
            task_state[cur] = ST_READY;
          end
          if (ring_count == 0) err = ERR_EMPTY;
          else sw = dispatch_head();
        end
      end
      ACT_BLOCK: begin
        if (it.block_kind > KIND_MAX) err = ERR_STATUS;
        else if (ring_count == 0) err = ERR_EMPTY;
        else begin
          task_state[cur] = status_t'(ST_BLOCKED + it.block_kind);
          sw = dispatch_head();
        end
      end
      ACT_UNBLOCK: begin
        if (!(task_state[id] inside {ST_BLOCKED, ST_WAITING, ST_HANGING})) err = ERR_STATUS;
        else if (is_queued(id) || ring_count >= MAX_TASKS) err = ERR_QUEUED;
        else begin
          ring_head--;
          ready_ring[ring_head] = id;
          ring_count++;
          task_state[id] = ST_READY;
        end
      end
      default: ;  // unused codes: no effect
    endcase
    r.running_task = running_id;
    r.switched     = sw;
    r.error_code   = err;
    return r;
  endfunction

  // Offer one action and hold it until the transfer; the expectation is queued
  // at the accepting edge. A typed row overrides the predicted result.
  task automatic offer_action(input act_item_t it, input logic typed, input res_item_t typed_res);
    res_item_t predicted;
    act_valid <= 1'b1;
    act_item  <= it;
    do @(posedge clk); while (act_stall);
    predicted = sched_next(it);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. typed = 1 rows carry an expectation read straight off the
  // spec; the rest go through the predictor.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    act_item_t item;
    logic      typed;
    res_item_t res;
  } dir_row_t;

  localparam int unsigned N_DIR = 26;

  dir_row_t dir_rows [N_DIR] = '{
    // empty scheduler: nothing to pop, bad kind, nothing to unblock
    '{'{ACT_YIELD,     4'd0,  KIND_BLOCKED}, 1'b1, '{4'd0, 1'b0, ERR_EMPTY}},
    '{'{ACT_BLOCK,     4'd15, KIND_BAD},     1'b1, '{4'd0, 1'b0, ERR_STATUS}},
    '{'{ACT_BLOCK,     4'd0,  KIND_BLOCKED}, 1'b1, '{4'd0, 1'b0, ERR_EMPTY}},
    '{'{ACT_UNBLOCK,   4'd15, KIND_BLOCKED}, 1'b1, '{4'd0, 1'b0, ERR_STATUS}},
    // unused action codes are ignored
    '{'{ACT_UNUSED_LO, 4'd0,  KIND_BLOCKED}, 1'b1, '{4'd0, 1'b0, ERR_OK}},
    '{'{ACT_UNUSED_HI, 4'd15, KIND_BAD},     1'b1, '{4'd0, 1'b0, ERR_OK}},
    // idle current task: yield just pops the head
    '{'{ACT_START,     4'd4,  KIND_BLOCKED}, 1'b0, '0},
    '{'{ACT_YIELD,     4'd0,  KIND_BLOCKED}, 1'b0, '0},
    '{'{ACT_INIT,      4'd0,  KIND_BLOCKED}, 1'b0, '0},
    '{'{ACT_START,     4'd15, KIND_HANGING}, 1'b0, '0},
    '{'{ACT_START,     4'd15, KIND_BLOCKED}, 1'b1, '{4'd0, 1'b0, ERR_QUEUED}},
    '{'{ACT_START,     4'd1,  KIND_BLOCKED}, 1'b0, '0},
    '{'{ACT_START,     4'd2,  KIND_BLOCKED}, 1'b0, '0},
    '{'{ACT_YIELD,     4'd0,  KIND_BLOCKED}, 1'b0, '0},
    // every block kind
    '{'{ACT_BLOCK,     4'd0,  KIND_WAITING}, 1'b0, '0},
    '{'{ACT_BLOCK,     4'd0,  KIND_HANGING}, 1'b0, '0},
    '{'{ACT_BLOCK,     4'd0,  KIND_BLOCKED}, 1'b0, '0},
    // lone running task yields to itself: no switch
    '{'{ACT_YIELD,     4'd0,  KIND_BLOCKED}, 1'b0, '0},
    '{'{ACT_UNBLOCK,   4'd15, KIND_BLOCKED}, 1'b0, '0},
    '{'{ACT_UNBLOCK,   4'd15, KIND_BLOCKED}, 1'b1, '{4'd0, 1'b0, ERR_STATUS}},
    '{'{ACT_UNBLOCK,   4'd1,  KIND_BLOCKED}, 1'b0, '0},
    '{'{ACT_UNBLOCK,   4'd2,  KIND_BLOCKED}, 1'b0, '0},
    // starting the current task queues it, so the next yield is refused
    '{'{ACT_START,     4'd0,  KIND_BLOCKED}, 1'b0, '0},
    '{'{ACT_YIELD,     4'd0,  KIND_BLOCKED}, 1'b1, '{4'd0, 1'b0, ERR_QUEUED}},
    '{'{ACT_INIT,      4'd3,  KIND_BLOCKED}, 1'b0, '0},
    '{'{ACT_YIELD,     4'd0,  KIND_BLOCKED}, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Action sender: reset, directed table, then random bursts with gaps.
  // ---------------------------------------------------------------------------
  initial begin : action_sender
    act_item_t         it;
    act_item_t         stim_q [$];
    logic [TASK_W-1:0] parked [$];
    int unsigned       burst;
    int unsigned       sent;
    int unsigned       roll;

    clear_sched_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) offer_action(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    sent = 0;
    while (sent < N_RANDOM) begin
      // mostly short bursts, now and then a long one with no idling
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (burst) begin
        if (stim_q.size() == 0) begin
          it.task_id    = TASK_W'($urandom_range(0, MAX_TASKS - 1));
          it.block_kind = ($urandom_range(0, 9) == 0) ? KIND_BAD : 2'($urandom_range(0, 2));
          roll = $urandom_range(0, 99);
          if (roll < 4) it.action = ACT_INIT;
          else if (roll < 30) it.action = ACT_START;
          else if (roll < 52) it.action = ACT_YIELD;
          else if (roll < 70) it.action = ACT_BLOCK;
          else if (roll < 94) begin
            // favor tasks that are actually parked so unblocks get through
            it.action = ACT_UNBLOCK;
            parked.delete();
            for (int t = 0; t < MAX_TASKS; t++)
              if (task_state[t] inside {ST_BLOCKED, ST_WAITING, ST_HANGING})
                parked.push_back(TASK_W'(t));
            if (parked.size() != 0 && $urandom_range(0, 3) != 0)
              it.task_id = parked[$urandom_range(0, parked.size() - 1)];
          end else if (roll < 97) begin
            // start every task in turn: drives the ring to full
            it.action = ACT_START;
            for (int t = 0; t < MAX_TASKS - 1; t++) begin
              it.task_id = TASK_W'(t);
              stim_q.push_back(it);
            end
            it.task_id = TASK_W'(MAX_TASKS - 1);
          end else begin
            it.action = 3'(ACT_UNUSED_LO + $urandom_range(0, 2));
          end
          stim_q.push_back(it);
        end
        it = stim_q.pop_front();
        offer_action(it, 1'b0, '0);
        if (it.action <= ACT_UNBLOCK) sent++;
      end
      act_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end

    act_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern: phases of random density, some with no stall, and
  // one long hold-off while the sender keeps offering, so the block backs up.
  // ---------------------------------------------------------------------------
  initial begin : res_stall_pattern
    int unsigned span;
    int unsigned pct;
    int unsigned cyc;
    bit          held;
    cyc  = 0;
    held = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      span = $urandom_range(10, 60);
      pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
      repeat (span) begin
        if (!held && cyc >= HOLDOFF_AT) begin
          held = 1'b1;
          res_stall <= 1'b1;
          repeat (HOLDOFF_LEN) begin
            @(posedge clk);
            cyc++;
          end
        end
        res_stall <= ($urandom_range(0, 99) < pct);
        @(posedge clk);
        cyc++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every result transfer against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    res_item_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: result transfer with nothing expected: expected none, actual %p",
                 $time, res_item);
      end else begin
        want = pending_results.pop_front();
        if (res_item.running_task !== want.running_task) begin
          fail_count++;
          $display("%0t: running_task expected %0d actual %0d",
                   $time, want.running_task, res_item.running_task);
        end
        if (res_item.switched !== want.switched) begin
          fail_count++;
          $display("%0t: switched expected %0b actual %0b",
                   $time, want.switched, res_item.switched);
        end
        if (res_item.error_code !== want.error_code) begin
          fail_count++;
          $display("%0t: error_code expected %0d actual %0d",
                   $time, want.error_code, res_item.error_code);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: cycle limit hit with %0d results outstanding",
               $time, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
